### sv/mcpf_pkg.sv
`default_nettype none
package mcpf_pkg;

    typedef enum logic [1:0] {
        OP_APPLY  = 2'd0,
        OP_TXDONE = 2'd1,
        OP_INIT   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_REAR_ADDR  = 2'd0,
        CFG_FRONT_ADDR = 2'd1,
        CFG_MAX_SPEED  = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    localparam logic [7:0] CMD_M1_FWD  = 8'd0;
    localparam logic [7:0] CMD_M1_REV  = 8'd1;
    localparam logic [7:0] CMD_M2_FWD  = 8'd4;
    localparam logic [7:0] CMD_M2_REV  = 8'd5;
    localparam logic [7:0] CMD_TIMEOUT = 8'd14;
    localparam logic [6:0] TIMEOUT_VALUE = 7'd3;

    localparam logic [7:0] RESET_REAR_ADDR  = 8'd128;
    localparam logic [7:0] RESET_FRONT_ADDR = 8'd129;
    localparam logic [6:0] RESET_MAX_SPEED  = 7'd127;

    localparam logic [3:0] LAST_IDX_APPLY = 4'd15;
    localparam logic [3:0] LAST_IDX_INIT  = 4'd7;

    localparam logic [15:0] RECIP_3 = 16'd43691;
    localparam int          RECIP_SHIFT = 17;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] front_left_volts;
        logic signed [15:0] front_right_volts;
        logic signed [15:0] rear_left_volts;
        logic signed [15:0] rear_right_volts;
    } t_in;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_out;

    typedef struct packed {
        logic [7:0] rear_address;
        logic [7:0] front_address;
        logic [6:0] max_speed;
    } t_cfg;

    // index 0 rear-left, 1 rear-right, 2 front-left, 3 front-right
    typedef struct packed {
        logic            is_init;
        logic [3:0]      rev;
        logic [3:0][6:0] speed;
    } t_cmd;

    // floor((|v|*127 + 1536) / 1024), the remaining divide by 3 follows later
    function automatic logic [11:0] scale_volts(input logic [15:0] raw);
        logic [16:0] m;
        logic [23:0] x;
        begin
            m = raw[15] ? (17'd0 - {raw[15], raw}) : {1'b0, raw};
            x = ({7'd0, m} << 7) - {7'd0, m} + 24'd1536;
            return x[21:10];
        end
    endfunction

    function automatic logic [6:0] clamp_speed(input logic [10:0] s,
                                               input logic [6:0] max_s);
        begin
            return (s > {4'd0, max_s}) ? max_s : s[6:0];
        end
    endfunction

endpackage
`default_nettype wire

### sv/mcpf_front.sv
`default_nettype none
module mcpf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire mcpf_pkg::t_in i_data,
    input  wire mcpf_pkg::t_cfg i_cfg,
    input  wire logic          i_q_full,
    output logic               o_push,
    output mcpf_pkg::t_cmd     o_push_data
);

    logic             r_busy;
    logic             n_busy;
    logic             r_s1_valid;
    logic             n_s1_valid;
    logic             r_s1_init;
    logic [3:0]       r_s1_rev;
    logic [3:0][11:0] r_s1_y;
    logic             acc;
    logic             take_apply;
    logic             take_init;
    logic [3:0][15:0] raw;
    logic [3:0][27:0] prod;

    assign o_stall    = r_s1_valid && i_q_full;
    assign acc        = i_valid && !o_stall;
    assign take_apply = (i_data.op == mcpf_pkg::OP_APPLY) && !r_busy;
    assign take_init  = (i_data.op == mcpf_pkg::OP_INIT);
    assign o_push     = r_s1_valid && !i_q_full;

    assign raw[0] = i_data.rear_left_volts;
    assign raw[1] = i_data.rear_right_volts;
    assign raw[2] = i_data.front_left_volts;
    assign raw[3] = i_data.front_right_volts;

    always_comb begin
        n_busy     = r_busy;
        n_s1_valid = r_s1_valid;
        if (o_push) begin
            n_s1_valid = 1'b0;
        end
        if (acc) begin
            n_s1_valid = take_apply || take_init;
            if (take_apply) begin
                n_busy = 1'b1;
            end else if (i_data.op == mcpf_pkg::OP_TXDONE) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_init <= take_init;
            for (int k = 0; k < 4; k++) begin
                r_s1_rev[k] <= raw[k][15];
                r_s1_y[k]   <= mcpf_pkg::scale_volts(raw[k]);
            end
        end
    end

    always_comb begin
        o_push_data.is_init = r_s1_init;
        o_push_data.rev     = r_s1_init ? 4'd0 : r_s1_rev;
        for (int k = 0; k < 4; k++) begin
            prod[k] = {16'd0, r_s1_y[k]} * {12'd0, mcpf_pkg::RECIP_3};
            if (r_s1_init) begin
                o_push_data.speed[k] = mcpf_pkg::clamp_speed({4'd0, mcpf_pkg::TIMEOUT_VALUE},
                                                             i_cfg.max_speed);
            end else begin
                o_push_data.speed[k] = mcpf_pkg::clamp_speed(
                    prod[k][mcpf_pkg::RECIP_SHIFT +: 11], i_cfg.max_speed);
            end
        end
    end

endmodule
`default_nettype wire

### sv/mcpf_queue.sv
`default_nettype none
module mcpf_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mcpf_pkg::t_cmd i_push_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_head_valid,
    output mcpf_pkg::t_cmd      o_head
);

    mcpf_pkg::t_cmd r_mem [mcpf_pkg::QDEPTH];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    assign o_full       = (r_count == 2'(mcpf_pkg::QDEPTH));
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

### sv/mcpf_back.sv
`default_nettype none
module mcpf_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mcpf_pkg::t_cfg i_cfg,
    input  wire logic           i_head_valid,
    input  wire mcpf_pkg::t_cmd i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output mcpf_pkg::t_out      o_data
);

    logic           r_valid;
    logic           n_valid;
    mcpf_pkg::t_out r_data;
    logic [3:0]     r_idx;
    logic [3:0]     n_idx;
    logic           load;
    logic           last;
    logic [1:0]     pkt;
    logic [7:0]     addr;
    logic [7:0]     cmd;
    logic [7:0]     speed;
    logic [7:0]     sum;
    logic [7:0]     tx;

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign load    = i_head_valid && (!r_valid || !i_stall);
    assign pkt     = r_idx[3:2];
    assign last    = i_head.is_init ? (r_idx == mcpf_pkg::LAST_IDX_INIT)
                                    : (r_idx == mcpf_pkg::LAST_IDX_APPLY);
    assign o_pop   = load && last;

    always_comb begin
        if (i_head.is_init) begin
            addr = (pkt == 2'd0) ? i_cfg.rear_address : i_cfg.front_address;
            cmd  = mcpf_pkg::CMD_TIMEOUT;
        end else begin
            addr = pkt[1] ? i_cfg.front_address : i_cfg.rear_address;
            if (pkt[0]) begin
                cmd = i_head.rev[pkt] ? mcpf_pkg::CMD_M2_REV : mcpf_pkg::CMD_M2_FWD;
            end else begin
                cmd = i_head.rev[pkt] ? mcpf_pkg::CMD_M1_REV : mcpf_pkg::CMD_M1_FWD;
            end
        end
        speed = {1'b0, i_head.speed[pkt]};
        sum   = (addr + cmd + speed) & 8'h7F;
        case (r_idx[1:0])
            2'd0:    tx = addr;
            2'd1:    tx = cmd;
            2'd2:    tx = speed;
            default: tx = sum;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = last ? 4'd0 : r_idx + 4'd1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.tx_byte   <= tx;
            r_data.last_byte <= last;
        end
    end

endmodule
`default_nettype wire

### sv/motor_command_packet_framer.sv
// Path: an accepted item is registered in the front stage, then in the command queue, and
// its first byte is registered at the output. Throughput: one byte per cycle while i_stall
// is low, 16 bytes per apply item and 8 per init item, set by the back-end byte serializer.
// A two-entry command queue lets the front accept while a burst drains.
// Reset: synchronous, active low; clears busy, queue, output valid and restores
// rear_address 128, front_address 129, max_speed 127.
`default_nettype none
module motor_command_packet_framer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire mcpf_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output mcpf_pkg::t_out      o_data,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [7:0]     i_cfg_data
);

    mcpf_pkg::t_cfg r_cfg;
    logic           q_full;
    logic           push;
    mcpf_pkg::t_cmd push_data;
    logic           pop;
    logic           head_valid;
    mcpf_pkg::t_cmd head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rear_address  <= mcpf_pkg::RESET_REAR_ADDR;
            r_cfg.front_address <= mcpf_pkg::RESET_FRONT_ADDR;
            r_cfg.max_speed     <= mcpf_pkg::RESET_MAX_SPEED;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mcpf_pkg::CFG_REAR_ADDR:  r_cfg.rear_address  <= i_cfg_data;
                mcpf_pkg::CFG_FRONT_ADDR: r_cfg.front_address <= i_cfg_data;
                mcpf_pkg::CFG_MAX_SPEED:  r_cfg.max_speed     <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    mcpf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .i_cfg       (r_cfg),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    mcpf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    mcpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );

endmodule
`default_nettype wire

### verif/motor_command_packet_framer_tb.sv
module motor_command_packet_framer_tb;
    import mcpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS = 100;
    localparam int N_DIR = 19;

    localparam logic [127:0] G_INIT    = 128'h800E0311_810E0312_00000000_00000000;
    localparam logic [127:0] G_MAX_POS = 128'h80007F7F_80047F03_81007F00_81047F04;
    localparam logic [127:0] G_MAX_NEG = 128'h80017F00_80057F04_81017F01_81057F05;
    localparam logic [127:0] G_ZERO    = 128'h80000000_80040004_81000001_81040005;
    localparam logic [127:0] G_NEG_MIN = 128'h80010001_80050005_81010002_81050006;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_in i_data = '0;
    logic i_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;
    logic o_stall;
    logic o_valid;
    logic o_cfg_ready;
    t_out o_data;

    motor_command_packet_framer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct packed {
        t_op          op;
        logic [15:0]  fl;
        logic [15:0]  fr;
        logic [15:0]  rl;
        logic [15:0]  rr;
        logic         typed;
        logic [4:0]   n_gold;
        logic [127:0] gold;
    } t_row;

    t_row dir_rows [N_DIR] = '{
        '{OP_INIT,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd8,  G_INIT},
        '{OP_APPLY,  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 5'd16, G_MAX_POS},
        '{OP_APPLY,  16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 5'd0,  128'd0},
        '{OP_INIT,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 5'd8,  G_INIT},
        '{OP_TXDONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd0,  128'd0},
        '{OP_TXDONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 5'd0,  128'd0},
        '{OP_APPLY,  16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 5'd16, G_MAX_NEG},
        '{OP_TXDONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd0,  128'd0},
        '{OP_APPLY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd16, G_ZERO},
        '{OP_TXDONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd0,  128'd0},
        '{OP_APPLY,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 5'd16, G_NEG_MIN},
        '{OP_TXDONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd0,  128'd0},
        '{OP_NONE,   16'h5A5A, 16'hA5A5, 16'h0F0F, 16'hF0F0, 1'b1, 5'd0,  128'd0},
        '{OP_APPLY,  16'h0C00, 16'hF400, 16'h0600, 16'hFA00, 1'b0, 5'd0,  128'd0},
        '{OP_TXDONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd0,  128'd0},
        '{OP_APPLY,  16'h7FFF, 16'h8000, 16'h8001, 16'h0001, 1'b0, 5'd0,  128'd0},
        '{OP_NONE,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd0,  128'd0},
        '{OP_APPLY,  16'h0300, 16'hFD00, 16'h1234, 16'hEDCC, 1'b1, 5'd0,  128'd0},
        '{OP_TXDONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd0,  128'd0}
    };

    t_cfg model_cfg;
    logic model_busy = 1'b0;
    t_out burst_q[$];
    t_out tx_expect_q[$];

    int errors = 0;
    int items_in = 0;
    int items_ignored = 0;
    int bytes_checked = 0;
    int cfg_writes = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit no_gaps = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_mode = 0;
    int stall_tick = 0;

    function automatic logic [6:0] volts_speed(input logic [15:0] raw, input logic [6:0] cap);
        logic [16:0] mag;
        logic [31:0] scaled;
        mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        scaled = ({15'd0, mag} * 32'd127 + 32'd1536) / 32'd3072;
        return (scaled > {25'd0, cap}) ? cap : scaled[6:0];
    endfunction

    task automatic add_packet(input logic [7:0] addr, input logic [7:0] cmd,
                              input logic [6:0] spd, input logic last_pkt);
        logic [8:0] sum;
        t_out b;
        sum = {1'b0, addr} + {1'b0, cmd} + {2'b0, spd};
        b.last_byte = 1'b0;
        b.tx_byte = addr;
        burst_q.push_back(b);
        b.tx_byte = cmd;
        burst_q.push_back(b);
        b.tx_byte = {1'b0, spd};
        burst_q.push_back(b);
        b.tx_byte = {1'b0, sum[6:0]};
        b.last_byte = last_pkt;
        burst_q.push_back(b);
    endtask

    task automatic frame_command(input t_in item);
        logic [6:0] timeout_spd;
        burst_q.delete();
        case (t_op'(item.op))
            OP_APPLY: begin
                if (!model_busy) begin
                    add_packet(model_cfg.rear_address,
                               item.rear_left_volts[15] ? CMD_M1_REV : CMD_M1_FWD,
                               volts_speed(item.rear_left_volts, model_cfg.max_speed), 1'b0);
                    add_packet(model_cfg.rear_address,
                               item.rear_right_volts[15] ? CMD_M2_REV : CMD_M2_FWD,
                               volts_speed(item.rear_right_volts, model_cfg.max_speed), 1'b0);
                    add_packet(model_cfg.front_address,
                               item.front_left_volts[15] ? CMD_M1_REV : CMD_M1_FWD,
                               volts_speed(item.front_left_volts, model_cfg.max_speed), 1'b0);
                    add_packet(model_cfg.front_address,
                               item.front_right_volts[15] ? CMD_M2_REV : CMD_M2_FWD,
                               volts_speed(item.front_right_volts, model_cfg.max_speed), 1'b1);
                    model_busy = 1'b1;
                end
            end
            OP_TXDONE: begin
                model_busy = 1'b0;
            end
            OP_INIT: begin
                timeout_spd = (TIMEOUT_VALUE > model_cfg.max_speed) ? model_cfg.max_speed
                                                                     : TIMEOUT_VALUE;
                add_packet(model_cfg.rear_address, CMD_TIMEOUT, timeout_spd, 1'b0);
                add_packet(model_cfg.front_address, CMD_TIMEOUT, timeout_spd, 1'b1);
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_item(input t_in item, input logic typed, input logic [4:0] n_gold,
                             input logic [127:0] gold);
        int gap;
        t_out b;
        if (burst_left == 0) begin
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data <= item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_in++;
        if (item.op == OP_NONE || (item.op == OP_APPLY && model_busy))
            items_ignored++;
        frame_command(item);
        if (typed) begin
            for (int k = 0; k < int'(n_gold); k++) begin
                b.tx_byte = gold[127 - 8 * k -: 8];
                b.last_byte = (k == int'(n_gold) - 1);
                tx_expect_q.push_back(b);
            end
        end else begin
            foreach (burst_q[k])
                tx_expect_q.push_back(burst_q[k]);
        end
    endtask

    function automatic logic [15:0] pick_volts();
        logic [15:0] mag;
        case ($urandom_range(0, 9))
            0, 1: return 16'($urandom);
            2: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'hFFFF;
                    3: return 16'h0001;
                    default: return 16'h0000;
                endcase
            end
            default: begin
                mag = 16'($urandom_range(0, 3328));
                return ($urandom_range(0, 1) == 1) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic t_op pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (model_busy) begin
            if (r < 55) return OP_TXDONE;
            if (r < 70) return OP_INIT;
            if (r < 88) return OP_APPLY;
            return OP_NONE;
        end
        if (r < 62) return OP_APPLY;
        if (r < 77) return OP_INIT;
        if (r < 90) return OP_TXDONE;
        return OP_NONE;
    endfunction

    task automatic run_random(input int target);
        int done;
        t_in item;
        t_op op;
        done = 0;
        while (done < target) begin
            op = pick_op();
            item.op = op;
            item.front_left_volts = pick_volts();
            item.front_right_volts = pick_volts();
            item.rear_left_volts = pick_volts();
            item.rear_right_volts = pick_volts();
            done++;
            send_item(item, 1'b0, 5'd0, '0);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (tx_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_REAR_ADDR: model_cfg.rear_address = value;
            CFG_FRONT_ADDR: model_cfg.front_address = value;
            CFG_MAX_SPEED: model_cfg.max_speed = value[6:0];
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        stall_tick++;
        if (stall_tick % 80 == 0)
            stall_mode = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= (stall_tick % 5 < 2);
                default: i_stall <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (tx_expect_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: expected none, actual tx_byte %02h last_byte %0b",
                             $time, o_data.tx_byte, o_data.last_byte);
            end else begin
                want = tx_expect_q.pop_front();
                bytes_checked++;
                if (o_data.tx_byte !== want.tx_byte) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: tx_byte expected %02h actual %02h",
                                 $time, want.tx_byte, o_data.tx_byte);
                end
                if (o_data.last_byte !== want.last_byte) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: last_byte expected %0b actual %0b",
                                 $time, want.last_byte, o_data.last_byte);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("motor_command_packet_framer regression: fail");
            $finish;
        end
    end

    initial begin
        t_in item;
        model_cfg.rear_address = RESET_REAR_ADDR;
        model_cfg.front_address = RESET_FRONT_ADDR;
        model_cfg.max_speed = RESET_MAX_SPEED;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            item.op = dir_rows[r].op;
            item.front_left_volts = dir_rows[r].fl;
            item.front_right_volts = dir_rows[r].fr;
            item.rear_left_volts = dir_rows[r].rl;
            item.rear_right_volts = dir_rows[r].rr;
            send_item(item, dir_rows[r].typed, dir_rows[r].n_gold, dir_rows[r].gold);
        end
        run_random(20);
        drain();

        write_reg(CFG_REAR_ADDR, 8'h00);
        write_reg(CFG_FRONT_ADDR, 8'hFF);
        write_reg(CFG_MAX_SPEED, 8'h00);
        write_reg(CFG_UNUSED, 8'hA5);
        run_random(25);
        drain();

        write_reg(CFG_REAR_ADDR, 8'hFF);
        write_reg(CFG_FRONT_ADDR, 8'h00);
        write_reg(CFG_MAX_SPEED, 8'hFF);
        run_random(25);
        drain();

        // hold the output side off while items keep coming
        write_reg(CFG_REAR_ADDR, 8'($urandom));
        write_reg(CFG_FRONT_ADDR, 8'($urandom));
        write_reg(CFG_MAX_SPEED, 8'($urandom_range(1, 10)));
        no_gaps = 1'b1;
        hold_req = 1'b1;
        run_random(12);
        no_gaps = 1'b0;
        run_random(13);
        drain();

        write_reg(CFG_REAR_ADDR, 8'($urandom));
        write_reg(CFG_FRONT_ADDR, 8'($urandom));
        write_reg(CFG_MAX_SPEED, 8'($urandom));
        run_random(20);
        drain();

        $display("covered %0d items (%0d dropped or unused op), %0d bytes checked",
                 items_in, items_ignored, bytes_checked);
        $display("%0d register writes across five address and speed cap settings",
                 cfg_writes);
        if (errors == 0)
            $display("motor_command_packet_framer regression: pass");
        else
            $display("motor_command_packet_framer regression: fail");
        $finish;
    end

endmodule
